>>> hw/rtl/arpc_pkg.sv
// shared types and constants of the arp cache table
package arpc_pkg;

  // field widths
  localparam int MAC_BYTES = 6;
  localparam int IP_W      = 32;
  localparam int MAC_W     = 8 * MAC_BYTES;
  localparam int TIME_W    = 16;
  localparam int TMO_W     = 15;
  localparam int CMD_W     = 2;
  localparam int ENT_W     = IP_W + MAC_W + TIME_W;

  // default table depth and timeout after reset
  localparam int ENTRIES_DEF = 128;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(15);

  // request codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // one stored entry, without its valid mark
  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] added;
  } ent_t;

  // verdict on the entry just read back from the store
  typedef struct packed {
    logic match;
    logic free;
    logic expired;
  } ent_flags_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

endpackage

>>> hw/rtl/arpc_ram.sv
// generic single-write, single-read ram with registered read data
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/arpc_match.sv
// compares the entry read back from the store against the current request
module arpc_match (
  input  logic [arpc_pkg::IP_W-1:0]   key_ip,
  input  logic [arpc_pkg::TIME_W-1:0] now,
  input  logic [arpc_pkg::TMO_W-1:0]  timeout,
  input  logic                        ent_valid,
  input  arpc_pkg::ent_t              ent,
  output arpc_pkg::ent_flags_t        flags
);

  logic [arpc_pkg::TIME_W-1:0] age;

  // wrapping age against the advanced time
  assign age = now - ent.added;

  always_comb begin
    flags.match   = ent_valid && (ent.ip == key_ip);
    flags.free    = !ent_valid;
    flags.expired = ent_valid && (age > {1'b0, timeout});
  end

endmodule

>>> hw/rtl/arpc_ctrl.sv
// scan sequencer: clearing pass, per-request table sweep and result registers
module arpc_ctrl #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request side
  input  logic                         start,
  output logic                         busy,
  input  logic [arpc_pkg::CMD_W-1:0]   in_cmd,
  input  logic [arpc_pkg::IP_W-1:0]    in_ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]   in_mac_addr,
  // result side
  output logic                         out_strobe,
  output logic                         out_hit,
  output logic [arpc_pkg::MAC_W-1:0]   out_found_mac,
  output logic                         out_stored,
  // store access
  output logic [$clog2(ENTRIES)-1:0]   rd_idx,
  output logic                         vld_we,
  output logic [$clog2(ENTRIES)-1:0]   wr_idx,
  output logic                         vld_wdata,
  output logic                         dat_we,
  output arpc_pkg::ent_t               dat_wdata,
  // entry verdict
  input  arpc_pkg::ent_flags_t         flags,
  input  logic [arpc_pkg::MAC_W-1:0]   ent_mac,
  output logic [arpc_pkg::IP_W-1:0]    key_ip,
  output logic [arpc_pkg::TIME_W-1:0]  now
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  arpc_pkg::state_t            state_r, state_nxt;
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  logic                        issue_on_r, issue_on_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]               chk_idx_r, chk_idx_nxt;
  logic [arpc_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [arpc_pkg::IP_W-1:0]   ip_r, ip_nxt;
  logic [arpc_pkg::MAC_W-1:0]  mac_r, mac_nxt;
  logic [arpc_pkg::TIME_W-1:0] now_r, now_nxt;
  logic                        strobe_r, strobe_nxt;
  logic                        hit_r, hit_nxt;
  logic [arpc_pkg::MAC_W-1:0]  found_r, found_nxt;
  logic                        stored_r, stored_nxt;
  logic                        done;

  // sequencer and accumulators
  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    issue_on_nxt = issue_on_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = rd_idx_r;
    cmd_nxt      = cmd_r;
    ip_nxt       = ip_r;
    mac_nxt      = mac_r;
    now_nxt      = now_r;
    strobe_nxt   = 1'b0;
    hit_nxt      = hit_r;
    found_nxt    = found_r;
    stored_nxt   = stored_r;
    vld_we       = 1'b0;
    wr_idx       = chk_idx_r;
    vld_wdata    = 1'b0;
    dat_we       = 1'b0;
    done         = 1'b0;
    unique case (state_r)
      arpc_pkg::ST_CLEAR: begin
        // one valid mark cleared per cycle
        vld_we = 1'b1;
        wr_idx = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          rd_idx_nxt = '0;
          state_nxt  = arpc_pkg::ST_IDLE;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      arpc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt      = in_cmd;
          ip_nxt       = in_ip_addr;
          mac_nxt      = in_mac_addr;
          rd_idx_nxt   = '0;
          issue_on_nxt = 1'b1;
          hit_nxt      = 1'b0;
          found_nxt    = '0;
          stored_nxt   = 1'b0;
          state_nxt    = arpc_pkg::ST_SCAN;
          // time advances before the ages are compared
          if (in_cmd == arpc_pkg::CMD_TICK) begin
            now_nxt = now_r + 1'b1;
          end
        end
      end
      arpc_pkg::ST_SCAN: begin
        // read issue, one entry per cycle
        chk_vld_nxt = issue_on_r;
        if (issue_on_r) begin
          if (rd_idx_r == LAST_IDX) begin
            issue_on_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        // evaluate the entry returned by the store
        if (chk_vld_r) begin
          case (cmd_r)
            arpc_pkg::CMD_LOOKUP: begin
              if (flags.match) begin
                hit_nxt   = 1'b1;
                found_nxt = ent_mac;
              end
            end
            arpc_pkg::CMD_INSERT: begin
              if (flags.free) begin
                vld_we     = 1'b1;
                vld_wdata  = 1'b1;
                dat_we     = 1'b1;
                stored_nxt = 1'b1;
                done       = 1'b1;
              end
            end
            arpc_pkg::CMD_TICK: begin
              if (flags.expired) begin
                vld_we = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (chk_idx_r == LAST_IDX) begin
            done = 1'b1;
          end
        end
        if (done) begin
          state_nxt    = arpc_pkg::ST_IDLE;
          strobe_nxt   = 1'b1;
          issue_on_nxt = 1'b0;
          chk_vld_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= arpc_pkg::ST_CLEAR;
      rd_idx_r   <= '0;
      issue_on_r <= 1'b0;
      chk_vld_r  <= 1'b0;
      now_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      issue_on_r <= issue_on_nxt;
      chk_vld_r  <= chk_vld_nxt;
      now_r      <= now_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    cmd_r     <= cmd_nxt;
    ip_r      <= ip_nxt;
    mac_r     <= mac_nxt;
    hit_r     <= hit_nxt;
    found_r   <= found_nxt;
    stored_r  <= stored_nxt;
  end

  assign busy            = (state_r != arpc_pkg::ST_IDLE);
  assign rd_idx          = rd_idx_r;
  assign dat_wdata.ip    = ip_r;
  assign dat_wdata.mac   = mac_r;
  assign dat_wdata.added = now_r;
  assign key_ip          = ip_r;
  assign now             = now_r;
  assign out_strobe      = strobe_r;
  assign out_hit         = hit_r;
  assign out_found_mac   = found_r;
  assign out_stored      = stored_r;

endmodule

>>> hw/rtl/arp_cache_table.sv
// top level of the arp cache table with aging
//
// Requests enter on start/busy: a request is taken at a clock edge where
// start is high and busy is low. in_cmd selects lookup, insert or
// one-second tick; in_ip_addr and in_mac_addr carry the key and the MAC.
// Every request gives exactly one result, shown on the out_ ports for one
// cycle with out_strobe high. The receiver cannot stall; out_hit,
// out_found_mac and out_stored keep it until the next request is taken.
// Each request sweeps the store, one entry read per cycle through the
// registered read port. A lookup or tick gives its result after the last
// entry is checked; an insert gives it when it fills a free slot, or after
// the last entry if none is free. busy drops in the result cycle, so a new
// request may be taken then. Writes back to the entry just checked never
// meet a read still to check; the sweep moves on one entry per cycle.
// After reset the valid marks are cleared in a pass with busy high; the
// time counter is zero and the timeout is 15. cfg_we/cfg_wdata write the
// timeout; the user is to do so only while idle, as the block won't check.
module arp_cache_table #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [arpc_pkg::CMD_W-1:0]  in_cmd,
  input  logic [arpc_pkg::IP_W-1:0]   in_ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]  in_mac_addr,
  output logic                        out_strobe,
  output logic                        out_hit,
  output logic [arpc_pkg::MAC_W-1:0]  out_found_mac,
  output logic                        out_stored,
  input  logic                        cfg_we,
  input  logic [arpc_pkg::TMO_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(ENTRIES);

  logic [arpc_pkg::TMO_W-1:0]  timeout_r;
  logic [AW-1:0]               rd_idx;
  logic [AW-1:0]               wr_idx;
  logic                        vld_we;
  logic                        vld_wdata;
  logic                        vld_rdata;
  logic                        dat_we;
  arpc_pkg::ent_t              dat_wdata;
  arpc_pkg::ent_t              dat_rdata;
  arpc_pkg::ent_flags_t        flags;
  logic [arpc_pkg::IP_W-1:0]   key_ip;
  logic [arpc_pkg::TIME_W-1:0] now;

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= arpc_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // valid marks
  arpc_ram #(
    .WIDTH (1),
    .DEPTH (ENTRIES)
  ) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (wr_idx),
    .wdata (vld_wdata),
    .raddr (rd_idx),
    .rdata (vld_rdata)
  );

  // address, mac and insert time
  arpc_ram #(
    .WIDTH (arpc_pkg::ENT_W),
    .DEPTH (ENTRIES)
  ) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (wr_idx),
    .wdata (dat_wdata),
    .raddr (rd_idx),
    .rdata (dat_rdata)
  );

  // entry compare
  arpc_match u_match (
    .key_ip    (key_ip),
    .now       (now),
    .timeout   (timeout_r),
    .ent_valid (vld_rdata),
    .ent       (dat_rdata),
    .flags     (flags)
  );

  // sweep sequencer
  arpc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_ip_addr    (in_ip_addr),
    .in_mac_addr   (in_mac_addr),
    .out_strobe    (out_strobe),
    .out_hit       (out_hit),
    .out_found_mac (out_found_mac),
    .out_stored    (out_stored),
    .rd_idx        (rd_idx),
    .vld_we        (vld_we),
    .wr_idx        (wr_idx),
    .vld_wdata     (vld_wdata),
    .dat_we        (dat_we),
    .dat_wdata     (dat_wdata),
    .flags         (flags),
    .ent_mac       (dat_rdata.mac),
    .key_ip        (key_ip),
    .now           (now)
  );

  // a result only appears once the sweep has ended
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while the sweep is still running");

  // a taken request always starts a sweep
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without starting a sweep");

  // an insert result never reports a lookup hit
  a_stored_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_stored) |-> !out_hit)
    else $error("insert result carries a hit");

  // mac is zero on a miss
  a_miss_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |-> (out_found_mac == '0))
    else $error("mac not zero on a miss");

endmodule
